@@ rtl/core/wgf_pkg.sv @@
// ----------------------------------------------------------------------------
// wgf_pkg
// Shared types, register indexes and helper functions for the widest free
// gap finder.
// ----------------------------------------------------------------------------
package wgf_pkg;

  localparam int ANGLE_W    = 8;
  localparam int DIST_W     = 12;
  localparam int CNT_W      = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;
  localparam int MAX_ITEMS_DEF = 64;

  localparam logic [DIST_W-1:0]  SAFE_DISTANCE_RST = 12'd30;
  localparam logic [ANGLE_W-1:0] MIN_GAP_WIDTH_RST = 8'd30;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] CFG_SAFE_DISTANCE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_GAP_WIDTH = 1'b1;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
    logic               new_scan;
    logic               descending;
  } wgf_in_t;

  typedef struct packed {
    logic               found;
    logic [ANGLE_W-1:0] center_angle;
  } wgf_out_t;

  // absolute angular span between two end angles
  function automatic logic [ANGLE_W-1:0] run_width(input logic [ANGLE_W-1:0] a,
                                                   input logic [ANGLE_W-1:0] b);
    run_width = (a > b) ? (a - b) : (b - a);
  endfunction

  // floor of the mean of the two end angles
  function automatic logic [ANGLE_W-1:0] run_centre(input logic [ANGLE_W-1:0] a,
                                                    input logic [ANGLE_W-1:0] b);
    logic [ANGLE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    run_centre = sum[ANGLE_W:1];
  endfunction

  // run of width w is a gap and beats the current best
  function automatic logic beats(input logic [ANGLE_W-1:0] w,
                                 input logic               valid,
                                 input logic [ANGLE_W-1:0] bw,
                                 input logic [ANGLE_W-1:0] min_w,
                                 input logic               later_wins);
    if (w == '0 || w < min_w) begin
      beats = 1'b0;
    end else if (!valid) begin
      beats = 1'b1;
    end else begin
      beats = (w > bw) || (later_wins && w == bw);
    end
  endfunction

endpackage

@@ rtl/core/wgf_tracker.sv @@
// ----------------------------------------------------------------------------
// wgf_tracker
// Per-scan run tracking state and the combinational result computation.
// ----------------------------------------------------------------------------
module wgf_tracker #(
  parameter int MAX_ITEMS = wgf_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  wgf_pkg::wgf_in_t             item,
  input  logic [wgf_pkg::DIST_W-1:0]   safe_distance,
  input  logic [wgf_pkg::ANGLE_W-1:0]  min_gap_width,
  output wgf_pkg::wgf_out_t            result
);

  localparam logic [wgf_pkg::CNT_W-1:0] CAP = wgf_pkg::CNT_W'(MAX_ITEMS);
  localparam logic [wgf_pkg::CNT_W-1:0] CNT_ONE = wgf_pkg::CNT_W'(1);

  logic [wgf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, c_cnt;
  logic                        in_run_r, in_run_nxt, c_in_run;
  logic [wgf_pkg::ANGLE_W-1:0] start_r, start_nxt, c_start;
  logic [wgf_pkg::ANGLE_W-1:0] end_r, end_nxt, c_end;
  logic [wgf_pkg::ANGLE_W-1:0] best_w_r, best_w_nxt, c_best_w;
  logic [wgf_pkg::ANGLE_W-1:0] best_c_r, best_c_nxt, c_best_c;
  logic                        best_v_r, best_v_nxt, c_best_v;
  logic [wgf_pkg::ANGLE_W-1:0] close_w, open_w;

  always_comb begin
    // new scan mark clears the scan before the item is taken
    c_cnt    = item.new_scan ? '0   : cnt_r;
    c_in_run = item.new_scan ? 1'b0 : in_run_r;
    c_start  = item.new_scan ? '0   : start_r;
    c_end    = item.new_scan ? '0   : end_r;
    c_best_w = item.new_scan ? '0   : best_w_r;
    c_best_c = item.new_scan ? '0   : best_c_r;
    c_best_v = item.new_scan ? 1'b0 : best_v_r;

    cnt_nxt    = c_cnt;
    in_run_nxt = c_in_run;
    start_nxt  = c_start;
    end_nxt    = c_end;
    best_w_nxt = c_best_w;
    best_c_nxt = c_best_c;
    best_v_nxt = c_best_v;
    close_w    = wgf_pkg::run_width(c_start, c_end);

    if (c_cnt < CAP) begin
      cnt_nxt = c_cnt + CNT_ONE;
      if (item.distance > safe_distance) begin
        if (!c_in_run) begin
          start_nxt = item.angle;
        end
        in_run_nxt = 1'b1;
        end_nxt    = item.angle;
      end else if (c_in_run) begin
        if (wgf_pkg::beats(close_w, c_best_v, c_best_w, min_gap_width,
                           item.descending)) begin
          best_w_nxt = close_w;
          best_c_nxt = wgf_pkg::run_centre(c_start, c_end);
          best_v_nxt = 1'b1;
        end
        in_run_nxt = 1'b0;
      end
    end
  end

  // result: best closed run, overridden by the open run if it wins
  always_comb begin
    open_w              = wgf_pkg::run_width(start_nxt, end_nxt);
    result.found        = best_v_nxt;
    result.center_angle = best_v_nxt ? best_c_nxt : '0;
    if (in_run_nxt && wgf_pkg::beats(open_w, best_v_nxt, best_w_nxt, min_gap_width,
                                     item.descending)) begin
      result.found        = 1'b1;
      result.center_angle = wgf_pkg::run_centre(start_nxt, end_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      in_run_r <= 1'b0;
      start_r  <= '0;
      end_r    <= '0;
      best_w_r <= '0;
      best_c_r <= '0;
      best_v_r <= 1'b0;
    end else if (accept) begin
      cnt_r    <= cnt_nxt;
      in_run_r <= in_run_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      best_w_r <= best_w_nxt;
      best_c_r <= best_c_nxt;
      best_v_r <= best_v_nxt;
    end
  end

  // count never passes capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP) else $error("item count beyond capacity");

  // a stored best is always a non-empty run, and none means zeroed fields
  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    best_v_r |-> best_w_r != '0) else $error("valid best of zero width");

  a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !best_v_r |-> (best_w_r == '0 && best_c_r == '0))
    else $error("stale best without valid");

  // an item at capacity leaves the count alone
  a_cap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !item.new_scan && cnt_r == CAP) |=> cnt_r == CAP)
    else $error("count moved at capacity");

endmodule

@@ rtl/core/wgf_out_stage.sv @@
// ----------------------------------------------------------------------------
// wgf_out_stage
// Result register with valid/stall handshake; back-pressures the input only
// while a held result is stalled.
// ----------------------------------------------------------------------------
module wgf_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wgf_pkg::wgf_out_t load_data,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output wgf_pkg::wgf_out_t out_data
);

  logic              valid_r, valid_nxt;
  wgf_pkg::wgf_out_t data_r;

  assign busy      = valid_r && out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  // a load never overwrites a result that is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !(valid_r && out_stall)) else $error("held result overwritten");

  // a loaded item is presented the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r) else $error("loaded item not shown");

  // with nothing loaded, a taken result leaves the stage empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_stall && !load) |=> !valid_r) else $error("result repeated");

endmodule

@@ rtl/core/widest_free_gap_finder_top.sv @@
// ----------------------------------------------------------------------------
// widest_free_gap_finder_top
// Tracks free runs of range detections within a scan and reports, for every
// detection, the centre of the widest acceptable gap seen so far.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in_      | input     | in_valid / in_stall | wgf_in_t  (angle, distance,
//           |           |                     |   new_scan, descending)
//  out_     | output    | out_valid/out_stall | wgf_out_t (found, center_angle)
//  cfg_     | input     | cfg_we              | cfg_addr, cfg_wdata
//
//  - One item per cycle unless stalled; each result appears in the cycle after
//    its item is taken. The whole update (clear, run open/close, best compare,
//    open-run compare) is one logic pass into tracker state and result register.
//  - in_stall rises only while a finished result is held under out_stall.
//  - rst_n (synchronous) empties the scan, drops any held result and sets
//    safe_distance and min_gap_width to 30.
//  - Config writes take effect on the next edge; write only when idle.
//
module widest_free_gap_finder_top #(
  parameter int MAX_ITEMS = wgf_pkg::MAX_ITEMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // detection input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wgf_pkg::wgf_in_t                in_data,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output wgf_pkg::wgf_out_t               out_data,
  // register writes
  input  logic                            cfg_we,
  input  logic [wgf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [wgf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [wgf_pkg::DIST_W-1:0]  safe_distance_r;
  logic [wgf_pkg::ANGLE_W-1:0] min_gap_width_r;
  logic                        in_accept;
  logic                        out_busy;
  wgf_pkg::wgf_out_t           result;

  // an item is taken unless the result register is full and stalled
  assign in_stall  = out_busy;
  assign in_accept = in_valid && !out_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_distance_r <= wgf_pkg::SAFE_DISTANCE_RST;
      min_gap_width_r <= wgf_pkg::MIN_GAP_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        wgf_pkg::CFG_SAFE_DISTANCE: begin
          safe_distance_r <= cfg_wdata[wgf_pkg::DIST_W-1:0];
        end
        wgf_pkg::CFG_MIN_GAP_WIDTH: begin
          min_gap_width_r <= cfg_wdata[wgf_pkg::ANGLE_W-1:0];
        end
        default: begin
          safe_distance_r <= safe_distance_r;
        end
      endcase
    end
  end

  // run tracking and result computation
  wgf_tracker #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .item          (in_data),
    .safe_distance (safe_distance_r),
    .min_gap_width (min_gap_width_r),
    .result        (result)
  );

  // result register
  wgf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .load_data (result),
    .busy      (out_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // no gap means centre reads as zero
  a_zero_centre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.found || out_data.center_angle == '0))
    else $error("centre set without a gap");

  // the input is held off only by a stalled, pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("spurious input stall");

  // every taken item leaves a result on the output next cycle
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid) else $error("taken item produced no result");

endmodule
